@@ sv/jddm_pkg.sv @@
package jddm_pkg;

  // Stick and drive formats
  localparam int AXIS_W  = 8;
  localparam int DRIVE_W = 8;

  // Full-scale axis value used by the premix
  localparam int AXIS_RANGE_DEF = 127;

  // Pivot limit register
  localparam int                   PIVOT_LIMIT_W   = 7;
  localparam logic [PIVOT_LIMIT_W-1:0] PIVOT_LIMIT_RST = 7'd32;

  // Quotient bits of the drive magnitude; the magnitude saturates at 2**QBITS-1
  localparam int QBITS = DRIVE_W - 1;

endpackage

@@ sv/jddm_div.sv @@
// Two-lane pipelined restoring divider: an entry stage, then one quotient bit per stage.
// Each lane divides an unsigned magnitude by a shared positive divisor and
// saturates the quotient to 2**QBITS-1.
module jddm_div #(
  parameter int NW = 34,
  parameter int DW = 22
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [NW-1:0]              in_mag_l,
  input  logic                       in_neg_l,
  input  logic [NW-1:0]              in_mag_r,
  input  logic                       in_neg_r,
  input  logic [DW-1:0]              in_den,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [jddm_pkg::QBITS-1:0] out_q_l,
  output logic                       out_neg_l,
  output logic [jddm_pkg::QBITS-1:0] out_q_r,
  output logic                       out_neg_r
);
  import jddm_pkg::*;

  logic [QBITS:0]    vld;
  logic [QBITS:0]    rdy;
  logic [NW-1:0]     rem_l [QBITS+1];
  logic [NW-1:0]     rem_r [QBITS+1];
  logic [QBITS-1:0]  q_l   [QBITS+1];
  logic [QBITS-1:0]  q_r   [QBITS+1];
  logic [QBITS:0]    ovf_l;
  logic [QBITS:0]    ovf_r;
  logic [QBITS:0]    neg_l;
  logic [QBITS:0]    neg_r;
  logic [DW-1:0]     den   [QBITS+1];
  logic [NW-1:0]     lim_in;
  logic              ovf_in_l;
  logic              ovf_in_r;

  // Stage ready: a stage takes new data when empty or when it drains
  genvar i;
  generate
    for (i = 0; i < QBITS; i++) begin : g_rdy
      assign rdy[i] = !vld[i] || rdy[i+1];
    end
  endgenerate
  assign rdy[QBITS] = !vld[QBITS] || out_ready;
  assign in_ready   = rdy[0];

  // Saturation check: the quotient must stay below 2**QBITS
  assign lim_in   = NW'(in_den) << QBITS;
  assign ovf_in_l = in_mag_l >= lim_in;
  assign ovf_in_r = in_mag_r >= lim_in;

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem_l[0] <= in_mag_l;
      rem_r[0] <= in_mag_r;
      q_l[0]   <= '0;
      q_r[0]   <= '0;
      ovf_l[0] <= ovf_in_l;
      ovf_r[0] <= ovf_in_r;
      neg_l[0] <= in_neg_l;
      neg_r[0] <= in_neg_r;
      den[0]   <= in_den;
    end
  end

  // One restoring step per stage, most significant quotient bit first
  generate
    for (i = 1; i <= QBITS; i++) begin : g_step
      localparam int K = QBITS - i;
      logic [NW-1:0] dsh;
      logic          ge_l;
      logic          ge_r;

      assign dsh  = NW'(den[i-1]) << K;
      assign ge_l = rem_l[i-1] >= dsh;
      assign ge_r = rem_r[i-1] >= dsh;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[i] && vld[i-1]) begin
          rem_l[i] <= ge_l ? rem_l[i-1] - dsh : rem_l[i-1];
          rem_r[i] <= ge_r ? rem_r[i-1] - dsh : rem_r[i-1];
          q_l[i]   <= {q_l[i-1][QBITS-2:0], ge_l};
          q_r[i]   <= {q_r[i-1][QBITS-2:0], ge_r};
          ovf_l[i] <= ovf_l[i-1];
          ovf_r[i] <= ovf_r[i-1];
          neg_l[i] <= neg_l[i-1];
          neg_r[i] <= neg_r[i-1];
          den[i]   <= den[i-1];
        end
      end
    end
  endgenerate

  // Clamp saturated lanes to full scale
  assign out_valid = vld[QBITS];
  assign out_q_l   = ovf_l[QBITS] ? {QBITS{1'b1}} : q_l[QBITS];
  assign out_q_r   = ovf_r[QBITS] ? {QBITS{1'b1}} : q_r[QBITS];
  assign out_neg_l = neg_l[QBITS];
  assign out_neg_r = neg_r[QBITS];

endmodule

@@ sv/joystick_differential_drive_mixer_top.sv @@
// Joystick differential drive mixer.
// Input stream (s_axis): one joystick sample per transfer, tdata holds
// stick_x in [7:0] and stick_y in [15:8], both two's complement.
// Output stream (m_axis): one result per sample, tdata holds left_drive in
// [7:0] and right_drive in [15:8], both two's complement in -127..+127.
// Configuration: cfg_we writes cfg_wdata into the pivot limit at the clock
// edge; write it only while no sample is in flight. A limit of 0 acts as 1.
// Throughput is one sample per cycle while m_axis_tready stays high. The
// pipeline holds the capture stage, three mixing stages (premix, products,
// sum and magnitude), an eight-stage divider whose entry stage is followed
// by one restoring step per quotient bit, and the output register.
// Reset: rst clears every valid bit and loads the pivot limit with 32.
// Stalls: when m_axis_tready is low the result holds on m_axis; stages
// behind it keep filling up any empty slots, so s_axis_tready only drops
// once the pipeline is full.
module joystick_differential_drive_mixer_top #(
  parameter int AXIS_RANGE = jddm_pkg::AXIS_RANGE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [2*jddm_pkg::AXIS_W-1:0]        s_axis_tdata,   // stick_x, stick_y
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [2*jddm_pkg::DRIVE_W-1:0]       m_axis_tdata,   // left_drive, right_drive
  input  logic                                 cfg_we,
  input  logic [jddm_pkg::PIVOT_LIMIT_W-1:0]   cfg_wdata       // pivot_limit
);
  import jddm_pkg::*;

  // Widths that follow from the axis range
  localparam int RW  = $clog2(AXIS_RANGE + 1);
  localparam int BW  = $clog2(AXIS_RANGE + 129) + 1;
  localparam int PW  = 2 * AXIS_W;
  localparam int M1W = BW + PW;
  localparam int RTW = RW + PIVOT_LIMIT_W;
  localparam int DW  = RTW;
  localparam int M2W = RTW + AXIS_W + 1;
  localparam int NSW = ((M1W > M2W) ? M1W : M2W) + 1;

  localparam logic signed [BW-1:0] RANGE_B = BW'(AXIS_RANGE);

  // Pivot limit register
  logic [PIVOT_LIMIT_W-1:0] pivot_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_limit <= PIVOT_LIMIT_RST;
    end else if (cfg_we) begin
      pivot_limit <= cfg_wdata;
    end
  end

  // Pipeline control
  logic v0, va, vb, vc, vo;
  logic r0, ra, rb, rc, ro;
  logic div_in_ready, div_out_valid;

  assign ro = !vo || m_axis_tready;
  assign rc = !vc || div_in_ready;
  assign rb = !vb || rc;
  assign ra = !va || rb;
  assign r0 = !v0 || ra;
  assign s_axis_tready = r0;

  // Stage 0: capture the sample
  logic signed [AXIS_W-1:0] x0, y0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (r0) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && s_axis_tvalid) begin
      x0 <= s_axis_tdata[AXIS_W-1:0];
      y0 <= s_axis_tdata[2*AXIS_W-1:AXIS_W];
    end
  end

  // Stage A: premix bases, throttle magnitude, divisor
  logic [AXIS_W-1:0]        ay;
  logic [PIVOT_LIMIT_W-1:0] lim;
  logic                     hi_n;
  logic [PIVOT_LIMIT_W-1:0] tgap;
  logic signed [BW-1:0]     xb;
  logic signed [BW-1:0]     base_l_n, base_r_n;

  always_comb begin
    ay   = y0[AXIS_W-1] ? AXIS_W'(-y0) : AXIS_W'(y0);
    lim  = (pivot_limit == '0) ? PIVOT_LIMIT_W'(1) : pivot_limit;
    hi_n = ay > {1'b0, lim};
    tgap = hi_n ? '0 : lim - ay[PIVOT_LIMIT_W-1:0];
    xb   = BW'(x0);
    if (!y0[AXIS_W-1]) begin
      base_l_n = x0[AXIS_W-1] ? RANGE_B + xb : RANGE_B;
      base_r_n = x0[AXIS_W-1] ? RANGE_B : RANGE_B - xb;
    end else begin
      base_l_n = x0[AXIS_W-1] ? RANGE_B : RANGE_B - xb;
      base_r_n = x0[AXIS_W-1] ? RANGE_B + xb : RANGE_B;
    end
  end

  logic signed [AXIS_W-1:0] xa, ya;
  logic signed [PW-1:0]     pa;
  logic                     hia;
  logic signed [BW-1:0]     base_la, base_ra;
  logic [RTW-1:0]           rta;
  logic [DW-1:0]            dena;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && v0) begin
      xa      <= x0;
      ya      <= y0;
      pa      <= PW'(y0) * PW'($signed({1'b0, ay}));
      hia     <= hi_n;
      base_la <= base_l_n;
      base_ra <= base_r_n;
      rta     <= RTW'(AXIS_RANGE) * RTW'(tgap);
      dena    <= hi_n ? DW'(AXIS_RANGE) : DW'(AXIS_RANGE) * DW'(lim);
    end
  end

  // Stage B: throttle products and pivot product
  logic signed [PW-1:0] sel;

  assign sel = hia ? PW'(ya) : pa;

  logic signed [M1W-1:0] m1_lb, m1_rb;
  logic signed [M2W-1:0] m2b;
  logic [DW-1:0]         denb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rb) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rb && va) begin
      m1_lb <= M1W'(base_la) * M1W'(sel);
      m1_rb <= M1W'(base_ra) * M1W'(sel);
      m2b   <= M2W'($signed({1'b0, rta})) * M2W'(xa);
      denb  <= dena;
    end
  end

  // Stage C: numerators, split into sign and magnitude
  logic signed [NSW-1:0] n_l, n_r;

  assign n_l = NSW'(m1_lb) + NSW'(m2b);
  assign n_r = NSW'(m1_rb) - NSW'(m2b);

  logic [NSW-1:0] mag_lc, mag_rc;
  logic           neg_lc, neg_rc;
  logic [DW-1:0]  denc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rc) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rc && vb) begin
      mag_lc <= n_l[NSW-1] ? NSW'(-n_l) : NSW'(n_l);
      mag_rc <= n_r[NSW-1] ? NSW'(-n_r) : NSW'(n_r);
      neg_lc <= n_l[NSW-1];
      neg_rc <= n_r[NSW-1];
      denc   <= denb;
    end
  end

  // Divide, truncating toward zero, with saturation
  logic [QBITS-1:0] q_l, q_r;
  logic             qneg_l, qneg_r;

  jddm_div #(
    .NW (NSW),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vc),
    .in_ready  (div_in_ready),
    .in_mag_l  (mag_lc),
    .in_neg_l  (neg_lc),
    .in_mag_r  (mag_rc),
    .in_neg_r  (neg_rc),
    .in_den    (denc),
    .out_valid (div_out_valid),
    .out_ready (ro),
    .out_q_l   (q_l),
    .out_neg_l (qneg_l),
    .out_q_r   (q_r),
    .out_neg_r (qneg_r)
  );

  // Output register: restore the sign
  logic signed [DRIVE_W-1:0] drv_l, drv_r;

  assign drv_l = qneg_l ? -DRIVE_W'(q_l) : DRIVE_W'(q_l);
  assign drv_r = qneg_r ? -DRIVE_W'(q_r) : DRIVE_W'(q_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (ro) begin
      vo <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ro && div_out_valid) begin
      m_axis_tdata <= {drv_r, drv_l};
    end
  end

  assign m_axis_tvalid = vo;

endmodule

@@ sv/jddm_chk.sv @@
// Port-level checks for the drive mixer
module jddm_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [2*jddm_pkg::DRIVE_W-1:0]      m_axis_tdata
);
  import jddm_pkg::*;

  localparam logic [DRIVE_W-1:0] DRIVE_MIN_CODE = {1'b1, {(DRIVE_W-1){1'b0}}};

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present right after reset");

  // An open output end means every stage can move, so the input is ready
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output side can drain");

  // Drives are saturated to the symmetric range
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[DRIVE_W-1:0] != DRIVE_MIN_CODE)
                   && (m_axis_tdata[2*DRIVE_W-1:DRIVE_W] != DRIVE_MIN_CODE))
    else $error("drive outside -127..+127");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind joystick_differential_drive_mixer_top jddm_chk u_jddm_chk (.*);

@@ verif/joystick_differential_drive_mixer_top_test.sv @@
`timescale 1ns / 100ps

module joystick_differential_drive_mixer_top_test;
  import jddm_pkg::*;

  localparam longint STICK_RANGE = longint'(AXIS_RANGE_DEF);

  // One result: left drive in the low byte, right drive in the high byte
  typedef struct packed {
    logic signed [DRIVE_W-1:0] right;
    logic signed [DRIVE_W-1:0] left;
  } drive_pair_t;

  // Mixer predictor with a queue of expected drive pairs
  class drive_scoreboard;
    logic [PIVOT_LIMIT_W-1:0] pivot_limit;
    drive_pair_t              pending_drives[$];
    int                       errors;
    int                       matched;

    function new();
      pivot_limit = PIVOT_LIMIT_RST;
      errors = 0;
      matched = 0;
    endfunction

    function void set_limit(logic [PIVOT_LIMIT_W-1:0] value);
      pivot_limit = value;
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction

    // Exact rational mix for one motor, truncated toward zero, then clamped
    function logic signed [DRIVE_W-1:0] blend_drive(longint base, longint y, longint ay,
                                                     longint lim, longint pivot);
      longint num;
      longint den;
      longint q;
      if (ay > lim) begin
        num = base * y;
        den = STICK_RANGE;
      end else begin
        num = ay * base * y + STICK_RANGE * (lim - ay) * pivot;
        den = STICK_RANGE * lim;
      end
      q = num / den;
      if (q > 127) q = 127;
      if (q < -127) q = -127;
      return q[DRIVE_W-1:0];
    endfunction

    function void note_sample(logic [2*AXIS_W-1:0] data);
      longint      x;
      longint      y;
      longint      ay;
      longint      lim;
      longint      base_l;
      longint      base_r;
      drive_pair_t drives;
      x = longint'($signed(data[AXIS_W-1:0]));
      y = longint'($signed(data[2*AXIS_W-1:AXIS_W]));
      ay = (y < 0) ? -y : y;
      // a limit of zero behaves as one
      lim = (pivot_limit == 0) ? 1 : longint'(pivot_limit);
      // premix base from the quadrant of the stick
      if (y >= 0) begin
        base_l = (x >= 0) ? STICK_RANGE : STICK_RANGE + x;
        base_r = (x >= 0) ? STICK_RANGE - x : STICK_RANGE;
      end else begin
        base_l = (x >= 0) ? STICK_RANGE - x : STICK_RANGE;
        base_r = (x >= 0) ? STICK_RANGE : STICK_RANGE + x;
      end
      drives.left = blend_drive(base_l, y, ay, lim, x);
      drives.right = blend_drive(base_r, y, ay, lim, -x);
      pending_drives.push_back(drives);
    endfunction

    function void check_drive(logic [2*DRIVE_W-1:0] data);
      drive_pair_t got;
      drive_pair_t want;
      got = data;
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected result, left %0d right %0d", $time, got.left, got.right);
        errors++;
        return;
      end
      want = pending_drives.pop_front();
      if (got.left !== want.left) begin
        $display("%0t: left_drive mismatch, expected %0d, actual %0d",
                 $time, want.left, got.left);
        errors++;
      end
      if (got.right !== want.right) begin
        $display("%0t: right_drive mismatch, expected %0d, actual %0d",
                 $time, want.right, got.right);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [2*AXIS_W-1:0]        s_axis_tdata;   // stick_x, stick_y
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [2*DRIVE_W-1:0]       m_axis_tdata;   // left_drive, right_drive
  logic                       cfg_we;
  logic [PIVOT_LIMIT_W-1:0]   cfg_wdata;      // pivot_limit

  drive_scoreboard sb = new();
  bit              sender_gaps;
  int              samples_sent;

  joystick_differential_drive_mixer_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Track register writes, accepted samples and delivered results on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_limit(cfg_wdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_drive(m_axis_tdata);
    end
  end

  // Result side: runs of ready, some very long, broken by stalls
  initial begin : ready_driver
    int run;
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (run) begin
        @(negedge clk);
        m_axis_tready <= 1'b1;
      end
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // After an optional random gap, present one sample and hold it until the transfer
  task automatic send_sample(input logic signed [AXIS_W-1:0] x,
                             input logic signed [AXIS_W-1:0] y);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
  endtask

  function automatic logic signed [AXIS_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return -8'sd128;
      1: return -8'sd127;
      2: return -8'sd1;
      3: return 8'sd0;
      4: return 8'sd1;
      default: return 8'sd127;
    endcase
  endfunction

  // Random sample, biased toward the pivot blend region and the axis ends
  task automatic send_random_sample();
    int                        r;
    int                        lim;
    int                        mag;
    logic signed [AXIS_W-1:0]  x;
    logic signed [AXIS_W-1:0]  y;
    lim = (sb.pivot_limit == 0) ? 1 : int'(sb.pivot_limit);
    r = $urandom_range(0, 9);
    if (r < 4) begin
      mag = $urandom_range(0, lim + 2);
      if (mag > 127) mag = 127;
      y = AXIS_W'($urandom_range(0, 1) ? -mag : mag);
    end else if (r < 5) begin
      y = pick_extreme();
    end else begin
      y = AXIS_W'($urandom_range(0, 255));
    end
    x = ($urandom_range(0, 9) == 0) ? pick_extreme() : AXIS_W'($urandom_range(0, 255));
    send_sample(x, y);
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [PIVOT_LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PIVOT_LIMIT_W-1:0] limits[9];
    int                       p;
    int                       i;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sender_gaps = 1'b1;
    samples_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners at the reset limit of 32
    send_sample(8'sd0, 8'sd0);
    send_sample(8'sd127, 8'sd127);
    send_sample(-8'sd127, -8'sd127);
    send_sample(-8'sd128, -8'sd128);
    send_sample(8'sd127, -8'sd128);
    send_sample(-8'sd128, 8'sd127);
    send_sample(8'sd0, 8'sd127);
    send_sample(8'sd0, -8'sd127);
    send_sample(8'sd127, 8'sd0);
    send_sample(-8'sd127, 8'sd0);
    send_sample(-8'sd128, 8'sd0);
    send_sample(8'sd0, -8'sd128);
    send_sample(8'sd100, 8'sd32);
    send_sample(-8'sd100, 8'sd33);
    send_sample(8'sd50, -8'sd32);
    send_sample(-8'sd50, -8'sd33);
    send_sample(8'sd1, 8'sd1);
    send_sample(-8'sd1, -8'sd1);
    send_sample(-8'sd128, 8'sd16);
    send_sample(-8'sd128, -8'sd16);
    send_sample(8'sd64, -8'sd1);
    send_sample(-8'sd85, 8'sd127);

    // Limit settings: zero, both ends, the reset value, then random ones
    limits[0] = '0;
    limits[1] = 7'd1;
    limits[2] = 7'd127;
    limits[3] = PIVOT_LIMIT_RST;
    for (p = 4; p < 9; p++) limits[p] = PIVOT_LIMIT_W'($urandom_range(1, 126));

    for (p = 0; p < 9; p++) begin
      drain();
      write_limit(limits[p]);
      sender_gaps = (p % 3) != 1;
      for (i = 0; i < 200; i++) begin
        // hold off the sender once until the pipeline runs dry
        if (p == 4 && i == 100) drain();
        send_random_sample();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d stick samples over %0d pivot limit settings (zero, 1, 127 included);",
             samples_sent, 10);
    $display("checked %0d drive pairs under random source gaps and sink stalls.", sb.matched);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("joystick_differential_drive_mixer_top regression: pass");
    end else begin
      $display("joystick_differential_drive_mixer_top regression: fail");
    end
    $finish;
  end

  // Give up after a generous bound
  initial begin : watchdog
    #4000000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("joystick_differential_drive_mixer_top regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
sv/jddm_pkg.sv
sv/jddm_div.sv
sv/joystick_differential_drive_mixer_top.sv
sv/jddm_chk.sv
verif/joystick_differential_drive_mixer_top_test.sv
